>>> rtl/tpbl_pkg.sv
package tpbl_pkg;

	// field widths of the port payload
	localparam int unsigned IDX_W  = 7;
	localparam int unsigned NPER_W = 7;
	localparam int unsigned PER_W  = 8;
	localparam int unsigned EL_W   = 7;

	// period count after reset
	localparam logic [NPER_W-1:0] NPER_RESET = 7'd8;

	// word modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_INDEX = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic out_load;
	} tpbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_last;
	} tpbl_stat_t;

endpackage

>>> rtl/tpbl_ctrl.sv
module tpbl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tpbl_pkg::tpbl_stat_t stat,
	output tpbl_pkg::tpbl_cmd_t  cmd
);
	import tpbl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WALK   = 5'b00010,
		ST_DRAIN1 = 5'b00100,
		ST_DRAIN2 = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_load;

	// output slot is free or being emptied
	assign can_load = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != ST_IDLE);
	assign cmd.accept   = in_valid && (state_q == ST_IDLE);
	assign cmd.rd_en    = (state_q == ST_WALK);
	assign cmd.out_load = (state_q == ST_FINISH) && can_load;
	assign out_valid    = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_d = (mode == MODE_QUERY) ? ST_WALK : ST_FINISH;
				end
			end
			ST_WALK: begin
				if (stat.rd_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a write word goes straight to the result stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && mode == MODE_WRITE) |=> (state_q == ST_FINISH))
		else $error("write word did not go to finish");

	// walk stops after the last entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && stat.rd_last) |=> !cmd.rd_en)
		else $error("read issued past the last entry");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

endmodule

>>> rtl/tpbl_dpath.sv
module tpbl_dpath #(
	parameter int unsigned MAX_PERIODS = 64,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tpbl_pkg::NPER_W-1:0]       cfg_wr_data,
	input  logic                              mode,
	input  logic [tpbl_pkg::IDX_W-1:0]        entry_index,
	input  logic [TIME_BITS-1:0]              time_value,
	input  tpbl_pkg::tpbl_cmd_t               cmd,
	output tpbl_pkg::tpbl_stat_t              stat,
	output logic                              status,
	output logic signed [tpbl_pkg::PER_W-1:0] plain_period,
	output logic signed [tpbl_pkg::PER_W-1:0] rounded_period,
	output logic [tpbl_pkg::EL_W-1:0]         early_period,
	output logic signed [tpbl_pkg::EL_W-1:0]  late_period
);
	import tpbl_pkg::*;

	localparam int unsigned AW = $clog2(MAX_PERIODS + 1);
	localparam int unsigned PW = $clog2(MAX_PERIODS + 2);
	localparam int unsigned TB = TIME_BITS;

	// table storage
	logic [TB-1:0] mem [0:MAX_PERIODS];

	logic [NPER_W-1:0] n_periods_q;
	logic [31:0]       n_wide;
	logic [AW-1:0]     n_used;
	logic [31:0]       idx_wide;
	logic              idx_bad;
	logic              mem_wr;

	logic          mode_q;
	logic          status_q;
	logic [TB-1:0] t_q;
	logic [AW-1:0] addr_q;
	logic [TB-1:0] prev_q;
	logic [PW-1:0] plain_pos_q;
	logic          plain_found_q;
	logic [PW-1:0] rnd_pos_q;
	logic          rnd_found_q;

	logic [TB-1:0] rd_data_s1;
	logic [AW-1:0] k_s1;
	logic          v_s1;
	logic [TB:0]   eff_a_s2;
	logic [TB:0]   eff_b_s2;
	logic [AW-1:0] k_s2;
	logic          v_s2;

	logic [TB:0]   d_ba;
	logic [TB:0]   d_ab;
	logic          ge;
	logic [TB-1:0] half;
	logic [TB:0]   a_m_h;
	logic [TB:0]   eff_a;
	logic [TB:0]   eff_b;

	logic [31:0] plain_w;
	logic [31:0] rnd_w;
	logic [31:0] late_w;

	logic [PER_W-1:0] plain_q;
	logic [PER_W-1:0] rounded_q;
	logic [EL_W-1:0]  early_q;
	logic [EL_W-1:0]  late_q;
	logic             out_status_q;

	// period count in use, clamped to 1..MAX_PERIODS
	always_comb begin
		n_wide = 32'(n_periods_q);
		if (n_periods_q == '0) begin
			n_wide = 32'd1;
		end else if (n_wide > MAX_PERIODS) begin
			n_wide = MAX_PERIODS;
		end
	end
	assign n_used = n_wide[AW-1:0];

	// write index check
	assign idx_wide = 32'(entry_index);
	assign idx_bad  = idx_wide > n_wide;
	assign mem_wr   = cmd.accept && (mode == MODE_WRITE) && !idx_bad;

	assign stat.rd_last = (addr_q == n_used);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_periods_q <= NPER_RESET;
		end else if (cfg_wr_en) begin
			n_periods_q <= cfg_wr_data;
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[idx_wide[AW-1:0]] <= time_value;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	// half period and effective starts of entry k-1 and k
	always_comb begin
		d_ba  = {1'b0, rd_data_s1} - {1'b0, prev_q};
		d_ab  = {1'b0, prev_q} - {1'b0, rd_data_s1};
		ge    = !d_ba[TB];
		half  = ge ? {1'b0, d_ba[TB-1:1]} : {1'b0, d_ab[TB-1:1]};
		a_m_h = {1'b0, prev_q} - {1'b0, half};
		eff_b = ge ? ({1'b0, rd_data_s1} - {1'b0, half})
		           : ({1'b0, rd_data_s1} + {1'b0, half});
		if (ge) begin
			eff_a = a_m_h[TB] ? '0 : a_m_h;
		end else begin
			eff_a = {1'b0, prev_q} + {1'b0, half};
		end
	end

	// query word, walk address and searches
	always_ff @(posedge clk) begin
		k_s1 <= addr_q;
		if (v_s1) begin
			prev_q   <= rd_data_s1;
			eff_a_s2 <= eff_a;
			eff_b_s2 <= eff_b;
			k_s2     <= k_s1;
		end
		if (cmd.accept) begin
			mode_q        <= mode;
			status_q      <= (mode == MODE_WRITE && idx_bad) ? STATUS_BAD_INDEX : STATUS_OK;
			t_q           <= time_value;
			addr_q        <= '0;
			plain_pos_q   <= PW'(n_used) + PW'(1);
			rnd_pos_q     <= PW'(n_used) + PW'(1);
			plain_found_q <= 1'b0;
			rnd_found_q   <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
			// plain search on stored starts
			if (v_s1 && !plain_found_q && (t_q < rd_data_s1)) begin
				plain_pos_q   <= PW'(k_s1);
				plain_found_q <= 1'b1;
			end
			// search on effective starts, entry 0 checked along with entry 1
			if (v_s2 && !rnd_found_q && (k_s2 != '0)) begin
				if ((k_s2 == AW'(1)) && ({1'b0, t_q} < eff_a_s2)) begin
					rnd_pos_q   <= '0;
					rnd_found_q <= 1'b1;
				end else if ({1'b0, t_q} < eff_b_s2) begin
					rnd_pos_q   <= PW'(k_s2);
					rnd_found_q <= 1'b1;
				end
			end
		end
	end

	// result formatting, found position minus one (minus two for the late period)
	assign plain_w = 32'(plain_pos_q) - 32'd1;
	assign rnd_w   = 32'(rnd_pos_q) - 32'd1;
	assign late_w  = 32'(rnd_pos_q) - 32'd2;

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			if (mode_q == MODE_QUERY) begin
				plain_q   <= plain_w[PER_W-1:0];
				rounded_q <= rnd_w[PER_W-1:0];
				early_q   <= (rnd_pos_q == '0) ? '0 : rnd_w[EL_W-1:0];
				late_q    <= (rnd_pos_q == '0) ? {EL_W{1'b1}} : late_w[EL_W-1:0];
			end else begin
				plain_q   <= '0;
				rounded_q <= '0;
				early_q   <= '0;
				late_q    <= '0;
			end
		end
	end

	assign status         = out_status_q;
	assign plain_period   = $signed(plain_q);
	assign rounded_period = $signed(rounded_q);
	assign early_period   = early_q;
	assign late_period    = $signed(late_q);

	// reads stay inside the used table
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (addr_q <= n_used))
		else $error("read address beyond used table");

	// compare stage only follows read data
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("compare stage without read data");

	// a new word finds the search pipeline empty
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (!v_s1 && !v_s2))
		else $error("word accepted while search still in flight");

endmodule

>>> rtl/timestamp_period_bucket_lookup.sv
// channel   signals                                           direction
// ------    ------------------------------------------------  ---------
// input     in_valid, in_stall, mode, entry_index, time_value  in
// output    out_valid, out_stall, status, plain_period,        out
//           rounded_period, early_period, late_period
// config    cfg_wr_en, cfg_wr_data (n_periods)                 in
//
// a write word goes straight to the result stage; a query word walks entries 0..n of the
// table, n being n_periods clamped to 1..MAX_PERIODS, through its one read port, one entry
// per cycle.
// one word is in work at a time; the next word is taken while a result waits.
// table contents are undefined after reset; n_periods resets to 8.
// out_stall holds the result register; work finishes and waits for it.
module timestamp_period_bucket_lookup #(
	parameter int unsigned MAX_PERIODS = 64,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tpbl_pkg::NPER_W-1:0]       cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [tpbl_pkg::IDX_W-1:0]        entry_index,
	input  logic [TIME_BITS-1:0]              time_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic signed [tpbl_pkg::PER_W-1:0] plain_period,
	output logic signed [tpbl_pkg::PER_W-1:0] rounded_period,
	output logic [tpbl_pkg::EL_W-1:0]         early_period,
	output logic signed [tpbl_pkg::EL_W-1:0]  late_period
);
	import tpbl_pkg::*;

	tpbl_cmd_t  cmd;
	tpbl_stat_t stat;

	// sequencer
	tpbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, searches and result register
	tpbl_dpath #(
		.MAX_PERIODS (MAX_PERIODS),
		.TIME_BITS   (TIME_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mode           (mode),
		.entry_index    (entry_index),
		.time_value     (time_value),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.plain_period   (plain_period),
		.rounded_period (rounded_period),
		.early_period   (early_period),
		.late_period    (late_period)
	);

endmodule

>>> tb/tb_timestamp_period_bucket_lookup.sv
`timescale 1ns / 100ps

module tb_timestamp_period_bucket_lookup;
	import tpbl_pkg::*;

	localparam int PERIODS_MAX  = 64;
	localparam int WORDS_TARGET = 950;
	localparam int QUIET_LIMIT  = 6000;

	typedef struct packed {
		logic       status;
		logic [7:0] plain;
		logic [7:0] rounded;
		logic [6:0] early;
		logic [6:0] late;
	} period_result_t;

	// mirror of the start table and period count, plus the results still owed
	class period_book;
		logic [31:0]       starts [0:PERIODS_MAX];
		bit                written [0:PERIODS_MAX];
		logic [NPER_W-1:0] n_reg;
		period_result_t    owed [$];
		int                errors;

		function new();
			n_reg = NPER_RESET;
			errors = 0;
			foreach (written[i]) written[i] = 1'b0;
			foreach (starts[i]) starts[i] = '0;
		endfunction

		// period count as the block uses it
		function int used();
			if (n_reg == 0) return 1;
			if (n_reg > PERIODS_MAX) return PERIODS_MAX;
			return n_reg;
		endfunction

		function bit table_ready();
			for (int i = 0; i <= used(); i++)
				if (!written[i]) return 1'b0;
			return 1'b1;
		endfunction

		// start moved half the gap toward entry k-1 (entry 0: away from 1), 33 bits wide
		function longint unsigned eff_start(int k);
			longint unsigned a, b, half;
			if (k == 0) begin
				a = starts[0];
				b = starts[1];
				if (b >= a) begin
					half = (b - a) / 2;
					return (half > a) ? 64'd0 : a - half;
				end
				return a + (a - b) / 2;
			end
			a = starts[k-1];
			b = starts[k];
			if (b >= a) return b - (b - a) / 2;
			return b + (a - b) / 2;
		endfunction

		// entry before the first whose (effective) start is above t, or n if there is none
		function int find_period(logic [31:0] t, bit effective);
			longint unsigned s;
			int n;
			n = used();
			for (int i = 0; i <= n; i++) begin
				s = effective ? eff_start(i) : {32'd0, starts[i]};
				if ({32'd0, t} < s) return i - 1;
			end
			return n;
		endfunction

		function void note_word(logic m, logic [IDX_W-1:0] idx, logic [31:0] t);
			period_result_t r;
			int plain, rounded, early, late;
			r = '0;
			if (m == MODE_WRITE) begin
				if (idx > used()) r.status = STATUS_BAD_INDEX;
				else begin
					starts[idx] = t;
					written[idx] = 1'b1;
				end
			end else begin
				plain = find_period(t, 1'b0);
				rounded = find_period(t, 1'b1);
				early = (rounded == -1) ? 0 : rounded;
				late = rounded - 1;
				if (late == -2) late = -1;
				r.status = STATUS_OK;
				r.plain = plain[7:0];
				r.rounded = rounded[7:0];
				r.early = early[6:0];
				r.late = late[6:0];
			end
			owed = {owed, r};
		endfunction

		function void check_result(period_result_t got);
			period_result_t want;
			if (owed.size() == 0) begin
				$error("result word with no word outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.plain !== want.plain) begin
				$error("plain_period: expected %0d, got %0d",
					$signed(want.plain), $signed(got.plain));
				errors++;
			end
			if (got.rounded !== want.rounded) begin
				$error("rounded_period: expected %0d, got %0d",
					$signed(want.rounded), $signed(got.rounded));
				errors++;
			end
			if (got.early !== want.early) begin
				$error("early_period: expected %0d, got %0d", want.early, got.early);
				errors++;
			end
			if (got.late !== want.late) begin
				$error("late_period: expected %0d, got %0d",
					$signed(want.late), $signed(got.late));
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [NPER_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              mode = MODE_WRITE;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [31:0]       time_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              status;
	logic signed [PER_W-1:0] plain_period;
	logic signed [PER_W-1:0] rounded_period;
	logic [EL_W-1:0]         early_period;
	logic signed [EL_W-1:0]  late_period;

	period_book book = new();
	int words_sent = 0;
	int send_idle_pct = 10;
	int recv_stall_pct = 88;
	int quiet_cycles = 0;

	timestamp_period_bucket_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.entry_index(entry_index),
		.time_value(time_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.plain_period(plain_period),
		.rounded_period(rounded_period),
		.early_period(early_period),
		.late_period(late_period)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result side: check each accepted word, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result({status, plain_period, rounded_period, early_period, late_period});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_timestamp_period_bucket_lookup: errors");
			$finish;
		end
	end

	// present one word, hold it until taken
	task automatic send_word(input logic m, input logic [IDX_W-1:0] idx, input logic [31:0] t);
		if (words_sent < 320) begin
			send_idle_pct = 10;
			recv_stall_pct = 88;
		end else if (words_sent < 640) begin
			send_idle_pct = 88;
			recv_stall_pct = 10;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		entry_index <= idx;
		time_value  <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book.note_word(m, idx, t);
		words_sent++;
	endtask

	// hold off until every owed result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (book.owed.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_periods(input logic [NPER_W-1:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.n_reg = value;
	endtask

	// write entries 0..n with a randomly shaped run of start times
	task automatic fill_starts();
		logic [31:0] v;
		int shape, n;
		n = book.used();
		shape = $urandom_range(99);
		v = '0;
		for (int i = 0; i <= n; i++) begin
			if (i == 0) begin
				if (shape < 30) v = $urandom_range(10);
				else if (shape < 65) v = $urandom_range(1 << 20);
				else if (shape < 75) v = 32'hFFFF_FFFF - 32'(4 * n) + $urandom_range(3);
				else v = $urandom;
			end else if (shape < 30 || (shape >= 65 && shape < 75)) begin
				v = v + $urandom_range(3);
			end else if (shape < 65) begin
				v = v + $urandom_range(1 << 24, 1);
			end else if (shape < 90) begin
				v = $urandom;
			end else begin
				v = v - $urandom_range(1 << 20);
			end
			send_word(MODE_WRITE, i[IDX_W-1:0], v);
		end
	endtask

	// lookup time near a start or effective start, at the extremes, or random
	function automatic logic [31:0] pick_time();
		longint unsigned e;
		logic [31:0] base;
		int k, r;
		k = $urandom_range(book.used(), 0);
		r = $urandom_range(99);
		if (r < 8) return 32'd0;
		if (r < 14) return 32'hFFFF_FFFF;
		if (r < 30) return $urandom;
		if (r < 65) base = book.starts[k];
		else begin
			e = book.eff_start(k);
			base = e[31:0];
		end
		return base + $urandom_range(4) - 2;
	endfunction

	initial begin
		logic [31:0]       dir_starts [0:8];
		logic [31:0]       dir_probes [0:10];
		logic [NPER_W-1:0] forced [0:3];
		logic [NPER_W-1:0] nval;
		int seg, r, nq;

		dir_starts = '{32'd5, 32'd100, 32'd200, 32'd1000, 32'd1001, 32'd5000, 32'd5000,
			32'd70000, 32'hFFFF_FFF0};
		dir_probes = '{32'd0, 32'd4, 32'd5, 32'd52, 32'd53, 32'd150, 32'd1000, 32'd5000,
			32'hFFFF_FFEF, 32'hFFFF_FFF0, 32'hFFFF_FFFF};
		forced = '{7'd1, 7'd64, 7'd127, 7'd0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table at the reset count, clamped first effective start,
		// ignored writes past the end, probes at zero, edges and the top
		for (int i = 0; i <= 8; i++) send_word(MODE_WRITE, i[IDX_W-1:0], dir_starts[i]);
		send_word(MODE_WRITE, 7'd9, 32'hFFFF_FFFF);
		send_word(MODE_WRITE, 7'd127, 32'd0);
		foreach (dir_probes[i])
			send_word(MODE_QUERY, IDX_W'($urandom_range(127)), dir_probes[i]);

		// random: new period count, table refill (always if incomplete, else at random), then lookups with some noise
		seg = 0;
		while (words_sent < WORDS_TARGET) begin
			if (seg < 4) nval = forced[seg];
			else begin
				r = $urandom_range(99);
				if (r < 5) nval = 7'd0;
				else if (r < 10) nval = 7'd64;
				else if (r < 13) nval = NPER_W'($urandom_range(127, 65));
				else if (r < 25) nval = 7'd1;
				else if (r < 32) nval = NPER_W'($urandom_range(63, 13));
				else nval = NPER_W'($urandom_range(12, 2));
			end
			seg++;
			write_periods(nval);
			if (!book.table_ready() || $urandom_range(99) < 60) fill_starts();
			nq = $urandom_range(40, 15);
			for (int q = 0; q < nq && words_sent < WORDS_TARGET; q++) begin
				if ($urandom_range(99) < 2) wait_drained();
				r = $urandom_range(99);
				if (r < 7)
					send_word(MODE_WRITE, IDX_W'($urandom_range(127, book.used() + 1)), $urandom);
				else if (r < 15)
					send_word(MODE_WRITE, IDX_W'($urandom_range(book.used(), 0)), $urandom);
				else
					send_word(MODE_QUERY, IDX_W'($urandom_range(127)), pick_time());
			end
		end

		// drain and let the block settle before the verdict
		in_valid <= 1'b0;
		while (book.owed.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (book.errors == 0 && book.owed.size() == 0)
			$display("tb_timestamp_period_bucket_lookup: clean");
		else
			$display("tb_timestamp_period_bucket_lookup: errors");
		$finish;
	end

endmodule
